// ===== src/hrv_pkg.sv =====
// ----------------------------------------------------------------------------
// hrv_pkg
// Shared types, constants and helpers of the HRV time-domain statistics block.
// ----------------------------------------------------------------------------
package hrv_pkg;

  localparam int INDEX_BITS = 32;
  localparam int RR_BITS    = 16;
  localparam int COUNT_BITS = 20;
  localparam int SUM_BITS   = 36;
  localparam int SQ_BITS    = 52;
  localparam int DSUM_BITS  = 38;
  localparam int DSQ_BITS   = 54;
  localparam int OUT_BITS   = 24;
  localparam int PNN_BITS   = 15;
  localparam int FS_BITS    = 14;
  localparam int CFG_BITS   = 16;
  localparam int AW         = 128;
  localparam int BW         = 64;
  localparam int ITER_BITS  = 7;

  localparam int QDEPTH     = 2;
  localparam int QPTR_BITS  = 1;
  localparam int QLVL_BITS  = 2;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [BW-1:0] MS16    = 64'd16000;
  localparam logic [BW-1:0] MS16_SQ = 64'd256000000;
  localparam logic [BW-1:0] PCT256  = 64'd25600;

  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_IVL  = 2'd2;

  localparam logic CFG_SAMPLE_RATE  = 1'b0;
  localparam logic CFG_NN_THRESHOLD = 1'b1;

  typedef struct packed {
    logic [INDEX_BITS-1:0] peak_index;
    logic                  last;
  } hrv_in_t;

  typedef struct packed {
    logic [OUT_BITS-1:0]   mean_rr;
    logic [OUT_BITS-1:0]   sdnn;
    logic [OUT_BITS-1:0]   rmssd;
    logic [OUT_BITS-1:0]   sdsd;
    logic [COUNT_BITS-1:0] nn_count;
    logic [PNN_BITS-1:0]   pnn;
    logic [COUNT_BITS-1:0] interval_count;
    logic                  stats_valid;
  } hrv_out_t;

  typedef struct packed {
    logic [FS_BITS-1:0]  sample_rate;
    logic [RR_BITS-1:0]  nn_threshold;
  } hrv_cfg_t;

  // one finished record, handed from front to back
  typedef struct packed {
    logic [COUNT_BITS-1:0]       cnt;
    logic [SUM_BITS-1:0]         rr_sum;
    logic [SQ_BITS-1:0]          rr_sq;
    logic signed [DSUM_BITS-1:0] diff_sum;
    logic [DSQ_BITS-1:0]         diff_sq;
    logic [COUNT_BITS-1:0]       nn;
  } hrv_rec_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } arith_op_e;

  typedef struct packed {
    logic          start;
    arith_op_e     op;
    logic [AW-1:0] a;
    logic [BW-1:0] b;
  } arith_req_t;

  typedef struct packed {
    logic          done;
    logic [AW-1:0] result;
  } arith_rsp_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ISSUE,
    BK_WAIT,
    BK_DONE
  } back_state_e;

  typedef enum logic [4:0] {
    ST_MEAN_P, ST_MEAN_D, ST_MEAN_Q, ST_FS2,
    ST_SD_A, ST_SD_B, ST_SD_K, ST_SD_D, ST_SD_Q1, ST_SD_Q2, ST_SD_R,
    ST_RM_K, ST_RM_Q1, ST_RM_Q2, ST_RM_R,
    ST_SS_A, ST_SS_B, ST_SS_K, ST_SS_D, ST_SS_Q1, ST_SS_Q2, ST_SS_R,
    ST_PN_P, ST_PN_Q
  } back_step_e;

  function automatic logic [OUT_BITS-1:0] sat_out(logic [AW-1:0] v);
    return (|v[AW-1:OUT_BITS]) ? {OUT_BITS{1'b1}} : v[OUT_BITS-1:0];
  endfunction

endpackage

// ===== src/hrv_arith.sv =====
// ----------------------------------------------------------------------------
// hrv_arith
// Shared iterative unit: shift-add multiply, restoring divide, integer root.
// ----------------------------------------------------------------------------
module hrv_arith (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hrv_pkg::arith_req_t req_i,
  output hrv_pkg::arith_rsp_t rsp_o
);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  hrv_pkg::arith_op_e         op_q, op_d;
  logic [hrv_pkg::ITER_BITS-1:0] cnt_q, cnt_d;
  logic [hrv_pkg::AW-1:0]     a_q, a_d;
  logic [hrv_pkg::BW-1:0]     b_q, b_d;
  logic [hrv_pkg::AW-1:0]     acc_q, acc_d;
  logic [67:0]                rem_q, rem_d;
  logic [hrv_pkg::BW-1:0]     root_q, root_d;

  logic [64:0] div_s;
  logic [67:0] sq_s, sq_t;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    root_d = root_q;
    div_s  = {rem_q[63:0], a_q[hrv_pkg::AW-1]};
    sq_s   = {rem_q[65:0], a_q[hrv_pkg::AW-1 -: 2]};
    sq_t   = {2'b00, root_q, 2'b01};
    if (!busy_q) begin
      if (req_i.start) begin
        busy_d = 1'b1;
        op_d   = req_i.op;
        a_d    = req_i.a;
        b_d    = req_i.b;
        acc_d  = '0;
        rem_d  = '0;
        root_d = '0;
        cnt_d  = (req_i.op == hrv_pkg::OP_DIV) ? 7'd127 : 7'd63;
      end
    end else begin
      unique case (op_q)
        hrv_pkg::OP_MUL: begin
          if (b_q[0]) acc_d = acc_q + a_q;
          a_d = {a_q[hrv_pkg::AW-2:0], 1'b0};
          b_d = {1'b0, b_q[hrv_pkg::BW-1:1]};
        end
        hrv_pkg::OP_DIV: begin
          if (div_s >= {1'b0, b_q}) begin
            rem_d = {3'b000, div_s - {1'b0, b_q}};
            a_d   = {a_q[hrv_pkg::AW-2:0], 1'b1};
          end else begin
            rem_d = {3'b000, div_s};
            a_d   = {a_q[hrv_pkg::AW-2:0], 1'b0};
          end
        end
        hrv_pkg::OP_SQRT: begin
          a_d = {a_q[hrv_pkg::AW-3:0], 2'b00};
          if (sq_s >= sq_t) begin
            rem_d  = sq_s - sq_t;
            root_d = {root_q[hrv_pkg::BW-2:0], 1'b1};
          end else begin
            rem_d  = sq_s;
            root_d = {root_q[hrv_pkg::BW-2:0], 1'b0};
          end
        end
        default: begin
          acc_d = acc_q;
        end
      endcase
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= hrv_pkg::OP_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  always_comb begin
    rsp_o.done = done_q;
    unique case (op_q)
      hrv_pkg::OP_MUL:  rsp_o.result = acc_q;
      hrv_pkg::OP_DIV:  rsp_o.result = a_q;
      hrv_pkg::OP_SQRT: rsp_o.result = {64'd0, root_q};
      default:          rsp_o.result = acc_q;
    endcase
  end

endmodule

// ===== src/hrv_queue.sv =====
// ----------------------------------------------------------------------------
// hrv_queue
// Two-entry queue of finished records between front and back.
// ----------------------------------------------------------------------------
module hrv_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  hrv_pkg::hrv_rec_t            push_data_i,
  input  logic                         pop_i,
  output hrv_pkg::hrv_rec_t            head_o,
  output logic                         not_empty_o,
  output logic [hrv_pkg::QLVL_BITS-1:0] level_o
);

  hrv_pkg::hrv_rec_t mem_q [hrv_pkg::QDEPTH];
  logic [hrv_pkg::QPTR_BITS-1:0] wr_q, rd_q;
  logic [hrv_pkg::QLVL_BITS-1:0] lvl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      lvl_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == hrv_pkg::QPTR_BITS'(hrv_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == hrv_pkg::QPTR_BITS'(hrv_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      lvl_q <= lvl_q + hrv_pkg::QLVL_BITS'(push_i) - hrv_pkg::QLVL_BITS'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  assign head_o      = mem_q[rd_q];
  assign not_empty_o = (lvl_q != '0);
  assign level_o     = lvl_q;

endmodule

// ===== src/hrv_front.sv =====
// ----------------------------------------------------------------------------
// hrv_front
// Forms RR intervals and differences and keeps the running record sums.
// ----------------------------------------------------------------------------
module hrv_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  hrv_pkg::hrv_in_t              in_data_i,
  input  logic [hrv_pkg::RR_BITS-1:0]   nn_threshold_i,
  input  logic [hrv_pkg::QLVL_BITS-1:0] q_level_i,
  output logic                          push_o,
  output hrv_pkg::hrv_rec_t             push_data_o
);

  logic accept;

  // record state
  logic [hrv_pkg::INDEX_BITS-1:0]     prev_peak_q;
  logic [hrv_pkg::RR_BITS-1:0]        prev_iv_q;
  logic [1:0]                         seen_q;
  logic [hrv_pkg::COUNT_BITS-1:0]     cnt_q;
  logic [hrv_pkg::SUM_BITS-1:0]       sum_q;
  logic signed [hrv_pkg::DSUM_BITS-1:0] dsum_q;
  logic [hrv_pkg::COUNT_BITS-1:0]     nn_q;
  logic [hrv_pkg::SQ_BITS-1:0]        sq_q;
  logic [hrv_pkg::DSQ_BITS-1:0]       dsq_q;

  // square stage
  logic                               b_vld_q, b_last_q, b_iv_en_q, b_d_en_q;
  logic [hrv_pkg::RR_BITS-1:0]        b_iv_q, b_ad_q;
  logic [hrv_pkg::COUNT_BITS-1:0]     b_cnt_q, b_nn_q;
  logic [hrv_pkg::SUM_BITS-1:0]       b_sum_q;
  logic signed [hrv_pkg::DSUM_BITS-1:0] b_dsum_q;

  logic [hrv_pkg::INDEX_BITS-1:0]     raw;
  logic [hrv_pkg::RR_BITS-1:0]        iv, ad;
  logic signed [hrv_pkg::RR_BITS:0]   dsig;
  logic                               upd, dupd;
  logic [hrv_pkg::COUNT_BITS-1:0]     cnt_n, nn_n;
  logic [hrv_pkg::SUM_BITS-1:0]       sum_n;
  logic signed [hrv_pkg::DSUM_BITS-1:0] dsum_n;
  logic [2*hrv_pkg::RR_BITS-1:0]      sq_iv, sq_ad;
  logic [hrv_pkg::SQ_BITS-1:0]        sq_n;
  logic [hrv_pkg::DSQ_BITS-1:0]       dsq_n;

  // leave room for a record still in the square stage
  assign in_stall_o = (q_level_i == hrv_pkg::QLVL_BITS'(hrv_pkg::QDEPTH)) ||
                      ((q_level_i == hrv_pkg::QLVL_BITS'(hrv_pkg::QDEPTH - 1)) &&
                       b_vld_q && b_last_q);
  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    raw    = in_data_i.peak_index - prev_peak_q;
    iv     = (|raw[hrv_pkg::INDEX_BITS-1:hrv_pkg::RR_BITS]) ? '1 : raw[hrv_pkg::RR_BITS-1:0];
    upd    = (seen_q != hrv_pkg::SEEN_NONE) && (cnt_q != hrv_pkg::CNT_MAX);
    dupd   = upd && (seen_q == hrv_pkg::SEEN_IVL);
    dsig   = $signed({1'b0, iv}) - $signed({1'b0, prev_iv_q});
    ad     = dsig[hrv_pkg::RR_BITS] ? hrv_pkg::RR_BITS'(-dsig) : dsig[hrv_pkg::RR_BITS-1:0];
    cnt_n  = cnt_q + hrv_pkg::COUNT_BITS'(upd);
    sum_n  = sum_q + (upd ? hrv_pkg::SUM_BITS'(iv) : '0);
    dsum_n = dsum_q + (dupd ? hrv_pkg::DSUM_BITS'(dsig) : '0);
    nn_n   = nn_q + hrv_pkg::COUNT_BITS'(dupd && (ad > nn_threshold_i));
    sq_iv  = b_iv_q * b_iv_q;
    sq_ad  = b_ad_q * b_ad_q;
    sq_n   = sq_q + (b_iv_en_q ? hrv_pkg::SQ_BITS'(sq_iv) : '0);
    dsq_n  = dsq_q + (b_d_en_q ? hrv_pkg::DSQ_BITS'(sq_ad) : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_peak_q <= '0;
      prev_iv_q   <= '0;
      seen_q      <= hrv_pkg::SEEN_NONE;
      cnt_q       <= '0;
      sum_q       <= '0;
      dsum_q      <= '0;
      nn_q        <= '0;
      sq_q        <= '0;
      dsq_q       <= '0;
      b_vld_q     <= 1'b0;
    end else begin
      b_vld_q <= accept;
      if (accept) begin
        if (in_data_i.last) begin
          prev_peak_q <= '0;
          prev_iv_q   <= '0;
          seen_q      <= hrv_pkg::SEEN_NONE;
          cnt_q       <= '0;
          sum_q       <= '0;
          dsum_q      <= '0;
          nn_q        <= '0;
        end else begin
          prev_peak_q <= in_data_i.peak_index;
          cnt_q       <= cnt_n;
          sum_q       <= sum_n;
          dsum_q      <= dsum_n;
          nn_q        <= nn_n;
          if (upd) begin
            prev_iv_q <= iv;
            seen_q    <= hrv_pkg::SEEN_IVL;
          end else if (seen_q == hrv_pkg::SEEN_NONE) begin
            seen_q    <= hrv_pkg::SEEN_ONE;
          end
        end
      end
      if (b_vld_q) begin
        if (b_last_q) begin
          sq_q  <= '0;
          dsq_q <= '0;
        end else begin
          sq_q  <= sq_n;
          dsq_q <= dsq_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_last_q  <= in_data_i.last;
      b_iv_en_q <= upd;
      b_d_en_q  <= dupd;
      b_iv_q    <= iv;
      b_ad_q    <= ad;
      b_cnt_q   <= cnt_n;
      b_sum_q   <= sum_n;
      b_dsum_q  <= dsum_n;
      b_nn_q    <= nn_n;
    end
  end

  assign push_o               = b_vld_q && b_last_q;
  assign push_data_o.cnt      = b_cnt_q;
  assign push_data_o.rr_sum   = b_sum_q;
  assign push_data_o.rr_sq    = sq_n;
  assign push_data_o.diff_sum = b_dsum_q;
  assign push_data_o.diff_sq  = dsq_n;
  assign push_data_o.nn       = b_nn_q;

endmodule

// ===== src/hrv_back.sv =====
// ----------------------------------------------------------------------------
// hrv_back
// Sequences the record-end arithmetic and holds the result register.
// ----------------------------------------------------------------------------
module hrv_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_not_empty_i,
  input  hrv_pkg::hrv_rec_t           q_head_i,
  output logic                        q_pop_o,
  input  logic [hrv_pkg::FS_BITS-1:0] sample_rate_i,
  output hrv_pkg::arith_req_t         req_o,
  input  hrv_pkg::arith_rsp_t         rsp_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output hrv_pkg::hrv_out_t           out_data_o
);

  hrv_pkg::back_state_e state_q, state_d;
  hrv_pkg::back_step_e  step_q, step_d;
  hrv_pkg::hrv_rec_t    rec_q;
  logic                 ok_q;
  logic [hrv_pkg::AW-1:0] t_q;
  logic [hrv_pkg::BW-1:0] d_q, f_q;
  logic [hrv_pkg::OUT_BITS-1:0] mean_q, sdnn_q, rmssd_q, sdsd_q;
  logic [hrv_pkg::PNN_BITS-1:0] pnn_q;
  logic                 out_vld_q;
  hrv_pkg::hrv_out_t    out_q;

  logic [hrv_pkg::FS_BITS-1:0]    fs;
  logic [hrv_pkg::COUNT_BITS-1:0] m;
  logic [hrv_pkg::DSUM_BITS-1:0]  ads;
  logic [hrv_pkg::AW-1:0]         r, t_sub;
  logic                           load_out, take;

  assign fs    = (sample_rate_i == '0) ? hrv_pkg::FS_BITS'(1) : sample_rate_i;
  assign m     = rec_q.cnt - hrv_pkg::COUNT_BITS'(1);
  assign ads   = rec_q.diff_sum[hrv_pkg::DSUM_BITS-1] ? hrv_pkg::DSUM_BITS'(-rec_q.diff_sum)
                                                      : rec_q.diff_sum;
  assign r     = rsp_i.result;
  assign t_sub = (t_q >= r) ? t_q - r : '0;
  assign take  = out_vld_q && !out_stall_i;

  // operand select per step
  always_comb begin
    req_o.start = (state_q == hrv_pkg::BK_ISSUE);
    req_o.op    = hrv_pkg::OP_MUL;
    req_o.a     = t_q;
    req_o.b     = d_q;
    unique case (step_q)
      hrv_pkg::ST_MEAN_P: begin
        req_o.a = hrv_pkg::AW'(rec_q.rr_sum);  req_o.b = hrv_pkg::MS16;
      end
      hrv_pkg::ST_MEAN_D: begin
        req_o.a = hrv_pkg::AW'(rec_q.cnt);     req_o.b = hrv_pkg::BW'(fs);
      end
      hrv_pkg::ST_FS2: begin
        req_o.a = hrv_pkg::AW'(fs);            req_o.b = hrv_pkg::BW'(fs);
      end
      hrv_pkg::ST_SD_A: begin
        req_o.a = hrv_pkg::AW'(rec_q.rr_sq);   req_o.b = hrv_pkg::BW'(rec_q.cnt);
      end
      hrv_pkg::ST_SD_B: begin
        req_o.a = hrv_pkg::AW'(rec_q.rr_sum);  req_o.b = hrv_pkg::BW'(rec_q.rr_sum);
      end
      hrv_pkg::ST_SD_K, hrv_pkg::ST_SS_K: begin
        req_o.b = hrv_pkg::MS16_SQ;
      end
      hrv_pkg::ST_SD_D: begin
        req_o.a = hrv_pkg::AW'(rec_q.cnt);     req_o.b = hrv_pkg::BW'(m);
      end
      hrv_pkg::ST_RM_K: begin
        req_o.a = hrv_pkg::AW'(rec_q.diff_sq); req_o.b = hrv_pkg::MS16_SQ;
      end
      hrv_pkg::ST_SS_A: begin
        req_o.a = hrv_pkg::AW'(rec_q.diff_sq); req_o.b = hrv_pkg::BW'(m);
      end
      hrv_pkg::ST_SS_B: begin
        req_o.a = hrv_pkg::AW'(ads);           req_o.b = hrv_pkg::BW'(ads);
      end
      hrv_pkg::ST_SS_D: begin
        req_o.a = hrv_pkg::AW'(m);
        req_o.b = hrv_pkg::BW'(m - hrv_pkg::COUNT_BITS'(1));
      end
      hrv_pkg::ST_PN_P: begin
        req_o.a = hrv_pkg::AW'(rec_q.nn);      req_o.b = hrv_pkg::PCT256;
      end
      hrv_pkg::ST_MEAN_Q, hrv_pkg::ST_SD_Q1, hrv_pkg::ST_SS_Q1: begin
        req_o.op = hrv_pkg::OP_DIV;
      end
      hrv_pkg::ST_SD_Q2, hrv_pkg::ST_RM_Q2, hrv_pkg::ST_SS_Q2: begin
        req_o.op = hrv_pkg::OP_DIV;            req_o.b = f_q;
      end
      hrv_pkg::ST_RM_Q1, hrv_pkg::ST_PN_Q: begin
        req_o.op = hrv_pkg::OP_DIV;            req_o.b = hrv_pkg::BW'(m);
      end
      hrv_pkg::ST_SD_R, hrv_pkg::ST_RM_R, hrv_pkg::ST_SS_R: begin
        req_o.op = hrv_pkg::OP_SQRT;
      end
      default: begin
        req_o.op = hrv_pkg::OP_MUL;
      end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    q_pop_o  = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      hrv_pkg::BK_IDLE: begin
        if (q_not_empty_i) begin
          q_pop_o = 1'b1;
          step_d  = hrv_pkg::ST_MEAN_P;
          state_d = (q_head_i.cnt >= hrv_pkg::COUNT_BITS'(3)) ? hrv_pkg::BK_ISSUE
                                                              : hrv_pkg::BK_DONE;
        end
      end
      hrv_pkg::BK_ISSUE: begin
        state_d = hrv_pkg::BK_WAIT;
      end
      hrv_pkg::BK_WAIT: begin
        if (rsp_i.done) begin
          if (step_q == hrv_pkg::ST_PN_Q) begin
            state_d = hrv_pkg::BK_DONE;
          end else begin
            step_d  = hrv_pkg::back_step_e'(step_q + 5'd1);
            state_d = hrv_pkg::BK_ISSUE;
          end
        end
      end
      hrv_pkg::BK_DONE: begin
        if (!out_vld_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = hrv_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = hrv_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= hrv_pkg::BK_IDLE;
      step_q    <= hrv_pkg::ST_MEAN_P;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (load_out)  out_vld_q <= 1'b1;
      else if (take) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      rec_q   <= q_head_i;
      ok_q    <= (q_head_i.cnt >= hrv_pkg::COUNT_BITS'(3));
      mean_q  <= '0;
      sdnn_q  <= '0;
      rmssd_q <= '0;
      sdsd_q  <= '0;
      pnn_q   <= '0;
    end
    if (state_q == hrv_pkg::BK_WAIT && rsp_i.done) begin
      unique case (step_q)
        hrv_pkg::ST_MEAN_D, hrv_pkg::ST_SD_D, hrv_pkg::ST_SS_D: d_q <= r[hrv_pkg::BW-1:0];
        hrv_pkg::ST_FS2:   f_q     <= r[hrv_pkg::BW-1:0];
        hrv_pkg::ST_MEAN_Q: mean_q <= hrv_pkg::sat_out(r);
        hrv_pkg::ST_SD_B, hrv_pkg::ST_SS_B: t_q <= t_sub;
        hrv_pkg::ST_SD_R:  sdnn_q  <= hrv_pkg::sat_out(r);
        hrv_pkg::ST_RM_R:  rmssd_q <= hrv_pkg::sat_out(r);
        hrv_pkg::ST_SS_R:  sdsd_q  <= hrv_pkg::sat_out(r);
        hrv_pkg::ST_PN_Q:  pnn_q   <= r[hrv_pkg::PNN_BITS-1:0];
        default:           t_q     <= r;
      endcase
    end
    if (load_out) begin
      out_q.mean_rr        <= mean_q;
      out_q.sdnn           <= sdnn_q;
      out_q.rmssd          <= rmssd_q;
      out_q.sdsd           <= sdsd_q;
      out_q.nn_count       <= rec_q.nn;
      out_q.pnn            <= pnn_q;
      out_q.interval_count <= rec_q.cnt;
      out_q.stats_valid    <= ok_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/hrv_time_domain_stats_top.sv =====
// ----------------------------------------------------------------------------
// hrv_time_domain_stats_top
// Time-domain HRV statistics (mean RR, SDNN, RMSSD, SDSD, NN count, pNN).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_stall_o/in_data_i carries one R-peak sample
//   index per transfer; last marks the final peak of a record. Output channel
//   out_valid_o/out_stall_i/out_data_o carries one result per record.
//   Peaks are taken one per cycle unless stalled: a two-stage front updates
//   the running sums (squares are accumulated in the following cycle). A
//   record end is queued (two entries) and worked off by a shared iterative
//   multiply/divide/root unit if the record has at least three intervals;
//   shorter records skip the arithmetic. Input stalls only while the record
//   queue is full, counting a record end that is still in the square stage.
//   The result sits in an output register until taken; a stalled receiver
//   holds it and the back end waits with the next record.
//   Reset clears all record state and the queue and loads sample_rate 360 and
//   nn_threshold 18. Write configuration through cfg_we_i only while idle.
// ----------------------------------------------------------------------------
module hrv_time_domain_stats_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  hrv_pkg::hrv_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output hrv_pkg::hrv_out_t            out_data_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [hrv_pkg::CFG_BITS-1:0] cfg_wdata_i
);

  hrv_pkg::hrv_cfg_t   cfg_q;
  logic                push, pop, not_empty;
  hrv_pkg::hrv_rec_t   push_data, head;
  logic [hrv_pkg::QLVL_BITS-1:0] level;
  hrv_pkg::arith_req_t req;
  hrv_pkg::arith_rsp_t rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_rate  <= hrv_pkg::FS_BITS'(360);
      cfg_q.nn_threshold <= hrv_pkg::RR_BITS'(18);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hrv_pkg::CFG_SAMPLE_RATE:  cfg_q.sample_rate  <= cfg_wdata_i[hrv_pkg::FS_BITS-1:0];
        hrv_pkg::CFG_NN_THRESHOLD: cfg_q.nn_threshold <= cfg_wdata_i[hrv_pkg::RR_BITS-1:0];
        default:                   cfg_q <= cfg_q;
      endcase
    end
  end

  hrv_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_data_i      (in_data_i),
    .nn_threshold_i (cfg_q.nn_threshold),
    .q_level_i      (level),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  hrv_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .not_empty_o (not_empty),
    .level_o     (level)
  );

  hrv_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  hrv_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_not_empty_i (not_empty),
    .q_head_i      (head),
    .q_pop_o       (pop),
    .sample_rate_i (cfg_q.sample_rate),
    .req_o         (req),
    .rsp_i         (rsp),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

endmodule
